// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== src/stt_pkg.sv =====
// Package for the alarm slot table: sizes, codes, transaction and control types.
// No dependencies.
package stt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int DIV_CNT_W  = 6;

  typedef enum logic [2:0] {
    MODE_ARM         = 3'd0,
    MODE_FREE_HANDLE = 3'd1,
    MODE_FREE_ID     = 3'd2,
    MODE_FREE_ALL    = 3'd3,
    MODE_DISPATCH    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_WAKEUP = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DIV,
    S_FINAL
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  event_id;
    logic        has_action;
    logic [31:0] delay;
    logic [31:0] period;
    logic [3:0]  handle;
    logic        handle_valid;
    logic [31:0] elapsed;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [3:0]  slot;
    logic [7:0]  fired_id;
    logic        fired_periodic;
    logic        reload;
    logic [31:0] timer_value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic div_start;
    logic final_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_dispatch;
    logic walk_done;
    logic need_div;
    logic div_done;
  } ctrl_sts_t;

endpackage

// ===== src/stt_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on stt_pkg.
module stt_div
  import stt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TIME_BITS-1:0] dividend_i,
  input  logic [TIME_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [TIME_BITS-1:0] rem_o
);

  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0] shf_q;
  logic [TIME_BITS-1:0] dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [TIME_BITS:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, shf_q[TIME_BITS-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = TIME_BITS'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      shf_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      shf_q  <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      shf_q <= {shf_q[TIME_BITS-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(TIME_BITS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/stt_ctrl.sv =====
// Sequencer for the alarm slot table: command execution and the dispatch walk.
// Depends on stt_pkg.
module stt_ctrl
  import stt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the sequence and issue datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_dispatch) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.walk_done) begin
          state_d = S_FINAL;
        end else if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.step = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_FINAL: begin
        cmd_o.final_emit = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/stt_datapath.sv =====
// Slot storage, arm and free logic, dispatch step and result register.
// Depends on stt_pkg and stt_div.
module stt_datapath
  import stt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      req_i,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  output logic      res_valid_o,
  output res_t      res_o
);

  req_t                 req_q;
  logic                 status_q [NUM_TIMERS];
  logic [7:0]           event_q  [NUM_TIMERS];
  logic [TIME_BITS-1:0] rem_q    [NUM_TIMERS];
  logic [TIME_BITS-1:0] period_q [NUM_TIMERS];
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     idx_q;
  logic [TIME_BITS-1:0] pending_q;
  logic [TIME_BITS-1:0] next_q;
  logic                 res_valid_q, res_valid_d;
  res_t                 res_q, res_d;

  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     top_idx;
  logic [TIME_BITS-1:0] total;
  logic                 active, expired, periodic;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 arm_sooner;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_rem;
  logic [TIME_BITS-1:0] reload_val;
  logic [TIME_BITS-1:0] count_down;

  assign cur        = idx_q[IDX_W-1:0];
  assign top_idx    = IDX_W'(cnt_q - 1'b1);
  assign total      = pending_q + req_q.elapsed;
  assign active     = status_q[cur];
  assign expired    = (rem_q[cur] <= total);
  assign periodic   = (period_q[cur] != '0);
  assign reload_val = period_q[cur] - div_rem;
  assign count_down = rem_q[cur] - total;
  assign arm_sooner = (pending_q > req_q.elapsed) &&
                      ((pending_q - req_q.elapsed) > req_q.delay);

  // Find the first free slot at or below one past the top used slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NUM_TIMERS - 1; j >= 0; j--) begin
      if (!status_q[j] && (CNT_W'(j) <= cnt_q)) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(j);
      end
    end
  end

  stt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(req_q.elapsed),
    .divisor_i (period_q[cur]),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    sts_o.is_dispatch = (req_q.mode == MODE_DISPATCH);
    sts_o.walk_done   = (idx_q >= cnt_q);
    sts_o.need_div    = (idx_q < cnt_q) && active && expired && periodic;
    sts_o.div_done    = div_done;
  end

  // Build the next result transaction
  always_comb begin
    res_valid_d = 1'b0;
    res_d       = '0;
    if (cmd_i.exec) begin
      res_valid_d = 1'b1;
      res_d.kind  = KIND_ACK;
      res_d.last  = 1'b1;
      if ((req_q.mode == MODE_ARM) && req_q.has_action && free_found) begin
        res_d.ok   = 1'b1;
        res_d.slot = free_idx;
        if (arm_sooner) begin
          res_d.reload      = 1'b1;
          res_d.timer_value = req_q.delay;
        end
      end
    end else if (cmd_i.step && active && expired) begin
      res_valid_d          = 1'b1;
      res_d.kind           = KIND_FIRED;
      res_d.slot           = cur;
      res_d.fired_id       = event_q[cur];
      res_d.fired_periodic = periodic;
    end else if (cmd_i.final_emit) begin
      res_valid_d       = 1'b1;
      res_d.kind        = KIND_WAKEUP;
      res_d.reload      = 1'b1;
      res_d.timer_value = next_q;
      res_d.last        = 1'b1;
    end
  end

  // Update slot state and register each result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_TIMERS; j++) begin
        status_q[j] <= 1'b0;
        event_q[j]  <= '0;
        rem_q[j]    <= '0;
        period_q[j] <= '0;
      end
      req_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      pending_q   <= '1;
      next_q      <= '1;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      res_q       <= res_d;

      if (cmd_i.load) begin
        req_q  <= req_i;
        idx_q  <= '0;
        next_q <= '1;
      end

      if (cmd_i.exec) begin
        case (req_q.mode)
          MODE_ARM: begin
            if (req_q.has_action && free_found) begin
              if (CNT_W'(free_idx) == cnt_q) begin
                cnt_q <= cnt_q + 1'b1;
              end
              if (arm_sooner) begin
                pending_q <= req_q.elapsed + req_q.delay;
              end
              event_q[free_idx]  <= req_q.event_id;
              rem_q[free_idx]    <= req_q.delay + req_q.elapsed;
              period_q[free_idx] <= req_q.period;
              status_q[free_idx] <= 1'b1;
            end
          end
          MODE_FREE_HANDLE: begin
            if (req_q.handle_valid) begin
              if ((cnt_q != '0) && (req_q.handle == top_idx)) begin
                cnt_q <= cnt_q - 1'b1;
              end
              status_q[req_q.handle] <= 1'b0;
            end
          end
          MODE_FREE_ID: begin
            for (int j = 0; j < NUM_TIMERS; j++) begin
              if ((CNT_W'(j) < cnt_q) && (event_q[j] == req_q.event_id)) begin
                status_q[j] <= 1'b0;
                event_q[j]  <= '0;
                rem_q[j]    <= '0;
                period_q[j] <= '0;
              end
            end
            if ((cnt_q != '0) && (event_q[top_idx] == req_q.event_id)) begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
          MODE_FREE_ALL: begin
            for (int j = 0; j < NUM_TIMERS; j++) begin
              if (CNT_W'(j) < cnt_q) begin
                status_q[j] <= 1'b0;
                event_q[j]  <= '0;
                rem_q[j]    <= '0;
                period_q[j] <= '0;
              end
            end
            cnt_q <= '0;
          end
          default: begin
          end
        endcase
      end

      // One slot of the dispatch walk
      if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
        if (active) begin
          if (expired) begin
            if (periodic) begin
              rem_q[cur] <= reload_val;
              if (reload_val < next_q) begin
                next_q <= reload_val;
              end
            end else begin
              status_q[cur] <= 1'b0;
              if (cur == top_idx) begin
                cnt_q <= cnt_q - 1'b1;
              end
            end
          end else begin
            rem_q[cur] <= count_down;
            if (count_down < next_q) begin
              next_q <= count_down;
            end
          end
        end
      end

      // Program the new wakeup
      if (cmd_i.final_emit) begin
        pending_q <= next_q;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/software_timer_table_top.sv =====
// Top level of the alarm slot table: controller, datapath and checks.
// Depends on stt_pkg, stt_ctrl, stt_datapath and assert_macros.svh.
//
// A command is taken when start is high and busy is low. Arm and the free
// modes answer with one acknowledge, built from the registered request in
// the execute state and then registered. Dispatch walks the used slots one
// per cycle, but an expired periodic slot holds the walk while it goes
// through the bit-serial remainder unit. Each fired slot gives one result,
// then the new wakeup closes the command. Results appear for one cycle
// with res_valid_o high and cannot be held off.
`include "assert_macros.svh"

module software_timer_table_top
  import stt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  stt_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  stt_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // A taken command keeps the block busy in the next cycle
  `ASSERT_CLK(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  // Results only come out of work in progress
  `ASSERT_CLK(a_res_from_busy, clk_i, rst_ni, res_valid_o |-> $past(busy))
  // The closing transaction is not followed at once by another
  `ASSERT_CLK(a_last_gap, clk_i, rst_ni, (res_valid_o && res_o.last) |=> !res_valid_o)
  // A fired slot never closes a command
  `ASSERT_NEVER(a_fired_last, clk_i, rst_ni, res_valid_o && (res_o.kind == KIND_FIRED) && res_o.last)

endmodule
